[hdl/lde_pkg.sv]
// Shared types and constants for the line discipline editor.
// No dependencies; imported by every module of the block except lde_ram.
package lde_pkg;

    localparam int LINE_DEPTH_DEF = 63;
    // Line length and queued counts; holds any depth up to 63.
    localparam int LEN_W          = 6;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_ERASE,
        CMD_LINE,
        CMD_OVF
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;
        logic [LEN_W-1:0]   count;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ERASE,
        B_LREAD,
        B_LPUT,
        B_LEND
    } back_state_t;

endpackage

[hdl/lde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lde_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/lde_cmd_fifo.sv]
// Short command queue between the front and back parts.
// Depends on lde_pkg (cmd_t, QUEUE_DEPTH, QPTR_W).
module lde_cmd_fifo
    import lde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/lde_front.sv]
// Front part: accepts input bytes, tracks CR and line length, writes the
// line store and queues at most one command per byte. Depends on lde_pkg.
module lde_front
    import lde_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF,
    parameter int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              push,
    output cmd_t              push_cmd,
    input  logic              full,
    input  logic              line_done,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output logic [7:0]        wdata
);

    logic             cr_seen_reg, cr_seen_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             pend_reg, pend_next;
    logic             accept;

    // Hold off new bytes while a line drains: its store entries are still read.
    assign in_ready = !full && !pend_reg;
    assign accept   = in_valid && in_ready;
    assign waddr    = len_reg[ADDR_W-1:0];
    assign wdata    = in_byte;

    always_comb
    begin
        push           = 1'b0;
        push_cmd.kind  = CMD_CHAR;
        push_cmd.data  = in_byte;
        push_cmd.count = len_reg;
        we             = 1'b0;
        len_next       = len_reg;
        cr_seen_next   = cr_seen_reg;
        pend_next      = pend_reg;
        if (line_done)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            if (cr_seen_reg && in_byte == CH_LF)
            begin
                cr_seen_next = 1'b0;
            end
            else
            begin
                cr_seen_next = (in_byte == CH_CR);
                case (in_byte) inside
                    CH_CR, CH_LF:
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_LINE;
                        len_next      = '0;
                        pend_next     = 1'b1;
                    end
                    CH_BS, CH_DEL:
                    begin
                        if (len_reg != '0)
                        begin
                            push          = 1'b1;
                            push_cmd.kind = CMD_ERASE;
                            len_next      = len_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        push = 1'b1;
                        if (len_reg >= LEN_W'(LINE_DEPTH))
                        begin
                            push_cmd.kind = CMD_OVF;
                        end
                        else
                        begin
                            push_cmd.kind = CMD_CHAR;
                            we            = 1'b1;
                            len_next      = len_reg + 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_seen_reg <= 1'b0;
            len_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            cr_seen_reg <= cr_seen_next;
            len_reg     <= len_next;
            pend_reg    <= pend_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_DEPTH))
        else $error("line length above store depth");

    a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> $past(push) && $past(push_cmd.kind) == CMD_LINE)
        else $error("line drain pending without a queued line");

    a_lf_swallow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cr_seen_reg && in_byte == CH_LF) |=>
            len_reg == $past(len_reg) && !cr_seen_reg)
        else $error("swallowed LF changed the line");

endmodule

[hdl/lde_back.sv]
// Back part: pops commands, reads the line store for line delivery and
// produces result items through an output register. Depends on lde_pkg.
module lde_back
    import lde_pkg::*;
#(
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              head,
    input  logic              empty,
    output logic              pop,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              line_done,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              echo_valid,
    output logic [7:0]        echo_byte,
    output logic              deliver_valid,
    output logic [7:0]        deliver_byte,
    output logic              overflow,
    output logic              last
);

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       deliver_valid;
        logic [7:0] deliver_byte;
        logic       overflow;
        logic       last;
    } res_t;

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       step_reg, step_next;
    logic             out_valid_reg;
    res_t             res_reg, res_next;
    logic             load;
    logic             slot_free;
    logic [LEN_W-1:0] idx_inc;

    assign slot_free = !out_valid_reg || out_ready;
    assign rd_addr   = idx_reg[ADDR_W-1:0];
    assign idx_inc   = idx_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        load       = 1'b0;
        res_next   = '0;
        rd_en      = 1'b0;
        line_done  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    case (head.kind)
                        CMD_LINE:
                        begin
                            pop      = 1'b1;
                            cnt_next = head.count;
                            idx_next = '0;
                            state_next = (head.count == '0) ? B_LEND : B_LREAD;
                        end
                        CMD_CHAR:
                        begin
                            if (slot_free)
                            begin
                                pop                 = 1'b1;
                                load                = 1'b1;
                                res_next.echo_valid = 1'b1;
                                res_next.echo_byte  = head.data;
                                res_next.last       = 1'b1;
                            end
                        end
                        CMD_OVF:
                        begin
                            if (slot_free)
                            begin
                                pop               = 1'b1;
                                load              = 1'b1;
                                res_next.overflow = 1'b1;
                                res_next.last     = 1'b1;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (slot_free)
                            begin
                                pop                 = 1'b1;
                                load                = 1'b1;
                                res_next.echo_valid = 1'b1;
                                res_next.echo_byte  = CH_BS;
                                step_next           = 2'd1;
                                state_next          = B_ERASE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_ERASE:
            begin
                if (slot_free)
                begin
                    load                = 1'b1;
                    res_next.echo_valid = 1'b1;
                    if (step_reg == 2'd1)
                    begin
                        res_next.echo_byte = CH_SP;
                        step_next          = 2'd2;
                    end
                    else
                    begin
                        res_next.echo_byte = CH_BS;
                        res_next.last      = 1'b1;
                        state_next         = B_IDLE;
                    end
                end
            end
            B_LREAD:
            begin
                rd_en      = 1'b1;
                state_next = B_LPUT;
            end
            B_LPUT:
            begin
                if (slot_free)
                begin
                    load                   = 1'b1;
                    res_next.deliver_valid = 1'b1;
                    res_next.deliver_byte  = rd_data;
                    idx_next               = idx_inc;
                    state_next = (idx_inc == cnt_reg) ? B_LEND : B_LREAD;
                end
            end
            B_LEND:
            begin
                if (slot_free)
                begin
                    load                   = 1'b1;
                    res_next.echo_valid    = 1'b1;
                    res_next.echo_byte     = CH_LF;
                    res_next.deliver_valid = 1'b1;
                    res_next.deliver_byte  = CH_LF;
                    res_next.last          = 1'b1;
                    line_done              = 1'b1;
                    state_next             = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign echo_valid    = res_reg.echo_valid;
    assign echo_byte     = res_reg.echo_byte;
    assign deliver_valid = res_reg.deliver_valid;
    assign deliver_byte  = res_reg.deliver_byte;
    assign overflow      = res_reg.overflow;
    assign last          = res_reg.last;

    a_put_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_LPUT |-> $past(state_reg) == B_LREAD || $past(state_reg) == B_LPUT)
        else $error("line byte taken without a store read");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LREAD || state_reg == B_LPUT) |-> idx_reg < cnt_reg)
        else $error("line read index past line length");

    a_erase_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ERASE |-> step_reg == 2'd1 || step_reg == 2'd2)
        else $error("erase sequence step out of range");

endmodule

[hdl/line_discipline_editor.sv]
// Top level of the line discipline editor: front part, command queue,
// line store RAM and back part. Depends on lde_pkg and all lde_* modules.
//
// Usage: raw terminal bytes enter on in_valid/in_ready/in_byte. Results
// leave on out_valid/out_ready with echo, deliver, overflow and last fields;
// the result that closes each input byte's results has last set, and bytes
// that cause no result (LF after CR, erase on an empty line) give none.
// A stored byte, an overflow or the first erase echo passes through the
// command queue and then the output register when the receiver is ready;
// the other two erase echoes follow one per cycle while out_ready is high;
// ordinary bytes sustain one per cycle until the four-entry queue fills.
// A line end of n stored bytes delivers them one by one: each delivered
// byte needs a line store read state and an output state. Input stays
// blocked (in_ready low) from the line end until its LF result is loaded,
// since new bytes would overwrite entries still being read.
// Reset clears the line length, the CR flag, the queue and the output
// register; the line store itself is not cleared. When out_ready is low the
// output register holds its item, the back part waits, and the queue then
// fills and drops in_ready.
module line_discipline_editor
    import lde_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       deliver_valid,
    output logic [7:0] deliver_byte,
    output logic       overflow,
    output logic       last
);

    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic              push, pop, full, empty;
    cmd_t              push_cmd, head;
    logic              line_done;
    logic              we, rd_en;
    logic [ADDR_W-1:0] waddr, rd_addr;
    logic [7:0]        wdata, rd_data;

    lde_front #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .line_done (line_done),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata)
    );

    lde_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    lde_ram #(
        .WIDTH  (8),
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    lde_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .line_done     (line_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_valid    (echo_valid),
        .echo_byte     (echo_byte),
        .deliver_valid (deliver_valid),
        .deliver_byte  (deliver_byte),
        .overflow      (overflow),
        .last          (last)
    );

endmodule

[dv/line_discipline_editor_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for line_discipline_editor: directed table, then random lines.
// Depends on lde_pkg and the line_discipline_editor RTL; predicts results itself.
module line_discipline_editor_tb;
    import lde_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int RAND_ITEMS   = 385;
    localparam int SETTLE_CYCLES = 2 * LINE_DEPTH_DEF + 40;

    typedef struct packed {
        logic       echo_v;
        logic [7:0] echo_b;
        logic       dlv_v;
        logic [7:0] dlv_b;
        logic       ovf;
        logic       lst;
    } line_result_t;

    // typed == 1: the row's item gives exactly n results, n of them being res
    typedef struct packed {
        logic [7:0]   b;
        logic [7:0]   reps;
        logic         typed;
        logic [1:0]   n;
        line_result_t res;
    } stim_row_t;

    localparam line_result_t NO_RES = '0;
    localparam line_result_t OVF_RES = '{1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1};

    localparam int DIR_ROWS = 21;
    localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
        '{CH_BS,  8'd1,  1'b1, 2'd0, NO_RES},                      // erase, empty line
        '{CH_DEL, 8'd1,  1'b1, 2'd0, NO_RES},
        '{CH_LF,  8'd1,  1'b1, 2'd1, '{1'b1, CH_LF, 1'b1, CH_LF, 1'b0, 1'b1}},
        '{8'h00,  8'd1,  1'b1, 2'd1, '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{8'hFF,  8'd1,  1'b1, 2'd1, '{1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{8'h41,  8'd1,  1'b1, 2'd1, '{1'b1, 8'h41, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{CH_BS,  8'd1,  1'b0, 2'd0, NO_RES},
        '{CH_DEL, 8'd1,  1'b0, 2'd0, NO_RES},
        '{CH_CR,  8'd1,  1'b0, 2'd0, NO_RES},
        '{CH_LF,  8'd1,  1'b1, 2'd0, NO_RES},                      // swallowed after CR
        '{CH_CR,  8'd1,  1'b0, 2'd0, NO_RES},
        '{CH_CR,  8'd1,  1'b0, 2'd0, NO_RES},                      // CR after CR is a line end
        '{8'h7A,  8'd1,  1'b0, 2'd0, NO_RES},
        '{CH_LF,  8'd1,  1'b0, 2'd0, NO_RES},
        '{8'h78,  8'd63, 1'b0, 2'd0, NO_RES},                      // fill the store
        '{8'h51,  8'd1,  1'b1, 2'd1, OVF_RES},
        '{CH_DEL, 8'd1,  1'b0, 2'd0, NO_RES},
        '{8'h71,  8'd1,  1'b0, 2'd0, NO_RES},
        '{8'h80,  8'd1,  1'b1, 2'd1, OVF_RES},
        '{CH_CR,  8'd1,  1'b0, 2'd0, NO_RES},                      // longest delivery
        '{CH_LF,  8'd1,  1'b1, 2'd0, NO_RES}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       deliver_valid;
    logic [7:0] deliver_byte;
    logic       overflow;
    logic       last;

    line_discipline_editor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_valid    (echo_valid),
        .echo_byte     (echo_byte),
        .deliver_valid (deliver_valid),
        .deliver_byte  (deliver_byte),
        .overflow      (overflow),
        .last          (last)
    );

    // predictor state
    logic         cr_pending = 1'b0;
    logic [7:0]   line_buf [LINE_DEPTH_DEF];
    int           line_len = 0;

    line_result_t expected_q [$];
    stim_row_t    row_tag_q [$];
    int           mismatches = 0;
    int           cycle_cnt = 0;
    int           rx_hold = 0;
    bit           no_idle = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic line_result_t mk_result(logic ev, logic [7:0] eb, logic dv,
                                               logic [7:0] db, logic ov, logic ls);
        line_result_t r;
        r.echo_v = ev;
        r.echo_b = eb;
        r.dlv_v  = dv;
        r.dlv_b  = db;
        r.ovf    = ov;
        r.lst    = ls;
        return r;
    endfunction

    // Appends one result to the tail of the expected queue.
    function automatic void expect_result(input line_result_t r);
        expected_q = {expected_q, r};
    endfunction

    // Runs one byte through the line editor; queues results only when emit is set.
    function automatic void edit_line(input logic [7:0] raw, input bit emit);
        logic [7:0] b;
        int         i;
        b = raw;
        if (cr_pending && b == CH_LF)
        begin
            cr_pending = 1'b0;
            return;
        end
        cr_pending = 1'b0;
        if (b == CH_CR)
        begin
            b = CH_LF;
            cr_pending = 1'b1;
        end
        if (b == CH_LF)
        begin
            for (i = 0; i < line_len; i++)
                if (emit)
                    expect_result(mk_result(1'b0, 8'h00, 1'b1, line_buf[i], 1'b0, 1'b0));
            if (emit)
                expect_result(mk_result(1'b1, CH_LF, 1'b1, CH_LF, 1'b0, 1'b1));
            line_len = 0;
        end
        else if (b == CH_BS || b == CH_DEL)
        begin
            if (line_len > 0)
            begin
                line_len--;
                if (emit)
                begin
                    expect_result(mk_result(1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 1'b0));
                    expect_result(mk_result(1'b1, CH_SP, 1'b0, 8'h00, 1'b0, 1'b0));
                    expect_result(mk_result(1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 1'b1));
                end
            end
        end
        else if (line_len >= LINE_DEPTH_DEF)
        begin
            if (emit)
                expect_result(OVF_RES);
        end
        else
        begin
            line_buf[line_len] = b;
            line_len++;
            if (emit)
                expect_result(mk_result(1'b1, b, 1'b0, 8'h00, 1'b0, 1'b1));
        end
    endfunction

    task automatic take_item(input logic [7:0] b);
        stim_row_t row;
        int        k;
        row = '0;
        if (row_tag_q.size() > 0)
            row = row_tag_q.pop_front();
        if (row.typed)
        begin
            edit_line(b, 1'b0);
            for (k = 0; k < row.n; k++)
                expect_result(row.res);
        end
        else
            edit_line(b, 1'b1);
    endtask

    task automatic check_result();
        line_result_t got;
        line_result_t want;
        got = mk_result(echo_valid, echo_byte, deliver_valid, deliver_byte, overflow, last);
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result ev=%b eb=%h dv=%b db=%h ovf=%b last=%b",
                         $realtime, got.echo_v, got.echo_b, got.dlv_v, got.dlv_b,
                         got.ovf, got.lst);
            return;
        end
        want = expected_q.pop_front();
        if (got.echo_v !== want.echo_v || got.echo_b !== want.echo_b ||
            got.dlv_v !== want.dlv_v || got.dlv_b !== want.dlv_b ||
            got.ovf !== want.ovf || got.lst !== want.lst)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: mismatch exp ev=%b eb=%h dv=%b db=%h ovf=%b last=%b",
                         $realtime, want.echo_v, want.echo_b, want.dlv_v, want.dlv_b,
                         want.ovf, want.lst);
                $display("%0t:          got ev=%b eb=%h dv=%b db=%h ovf=%b last=%b",
                         $realtime, got.echo_v, got.echo_b, got.dlv_v, got.dlv_b,
                         got.ovf, got.lst);
            end
        end
    endtask

    // Both handshakes are sampled at the edge, before any driver update lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                take_item(in_byte);
            if (out_valid && out_ready)
                check_result();
        end
    end

    // Receiver: a fresh stall count after every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            rx_hold = no_idle ? 0 : $urandom_range(0, 5);
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Holds the sender off until every queued result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL);
        return b;
    endfunction

    initial
    begin
        int r;
        int k;
        int sent;
        int lines;
        int len;
        int kind;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
            for (k = 0; k < DIR_TBL[r].reps; k++)
            begin
                row_tag_q = {row_tag_q, DIR_TBL[r]};
                put_byte(DIR_TBL[r].b);
            end
        drain_results();

        sent  = 0;
        lines = 0;
        while (sent < RAND_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // noise: any byte at all
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                    put_byte(8'($urandom_range(0, 255)));
                sent += len;
            end
            else
            begin
                len = (kind == 1) ? $urandom_range(58, 70) : $urandom_range(0, 12);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        put_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
                    else
                        put_byte(text_byte());
                end
                sent += len;
                case ($urandom_range(0, 3))
                    0: put_byte(CH_CR);
                    1: put_byte(CH_LF);
                    2:
                    begin
                        put_byte(CH_CR);
                        put_byte(CH_LF);
                        sent++;
                    end
                    default:
                    begin
                        put_byte(CH_LF);
                        put_byte(CH_CR);
                        sent++;
                    end
                endcase
                sent++;
            end
            lines++;
            if (lines % 20 == 7)
                drain_results();
        end

        no_idle = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
